@@ hdl/bisr_pkg.sv @@
`timescale 1ns / 1ps

package bisr_pkg;

  // field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned TOL_W   = VALUE_W - 1;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IN_W    = 3 * VALUE_W;

  // configuration reset values
  localparam logic [STEP_W-1:0] STEP_LIMIT_RST = STEP_W'(1000);
  localparam logic [TOL_W-1:0]  TOLERANCE_RST  = TOL_W'(7);

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_STEP_LIMIT = 2'd0;
  localparam logic [IDX_W-1:0] REG_TOLERANCE  = 2'd1;
  localparam logic [IDX_W-1:0] REG_USE_VALUE  = 2'd2;
  localparam logic [IDX_W-1:0] REG_USE_WIDTH  = 2'd3;

  // input commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_VALUE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2,
    PH_MID  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_EVAL    = 2'd0,
    ST_FOUND   = 2'd1,
    ST_NOCONV  = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef struct packed {
    logic [STEP_W-1:0] step_limit;
    logic [TOL_W-1:0]  tolerance;
    logic              use_value;
    logic              use_width;
  } cfg_t;

  typedef struct packed {
    phase_e             phase;
    logic [VALUE_W-1:0] low_end;
    logic [VALUE_W-1:0] high_end;
    logic [VALUE_W-1:0] low_value;
    logic [VALUE_W-1:0] last_mid;
    logic [STEP_W-1:0]  steps_done;
  } state_t;

  typedef struct packed {
    logic               cmd;
    logic [VALUE_W-1:0] end_a;
    logic [VALUE_W-1:0] end_b;
    logic [VALUE_W-1:0] func_value;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] point;
  } result_t;

  // floor((a+b)/2) without overflow
  function automatic logic [VALUE_W-1:0] midpoint(input logic [VALUE_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b);
    logic [VALUE_W-1:0] ha;
    logic [VALUE_W-1:0] hb;
    ha = {a[VALUE_W-1], a[VALUE_W-1:1]};
    hb = {b[VALUE_W-1], b[VALUE_W-1:1]};
    return ha + hb + {{(VALUE_W-1){1'b0}}, a[0] & b[0]};
  endfunction

  // magnitude, most negative value maps to 2^(w-1)
  function automatic logic [VALUE_W-1:0] mag(input logic [VALUE_W-1:0] x);
    return x[VALUE_W-1] ? (~x + VALUE_W'(1)) : x;
  endfunction

  function automatic logic is_neg(input logic [VALUE_W-1:0] x);
    return x[VALUE_W-1];
  endfunction

  function automatic logic is_pos(input logic [VALUE_W-1:0] x);
    return !x[VALUE_W-1] && (x != '0);
  endfunction

  // signs strictly opposite, neither zero
  function automatic logic brackets(input logic [VALUE_W-1:0] x,
                                    input logic [VALUE_W-1:0] y);
    return (is_neg(x) && is_pos(y)) || (is_pos(x) && is_neg(y));
  endfunction

endpackage

@@ hdl/bisr_cfg.sv @@
`timescale 1ns / 1ps

module bisr_cfg import bisr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STEP_LIMIT: cfg_d.step_limit = cfg_data_i[STEP_W-1:0];
        REG_TOLERANCE:  cfg_d.tolerance  = cfg_data_i[TOL_W-1:0];
        REG_USE_VALUE:  cfg_d.use_value  = cfg_data_i[0];
        REG_USE_WIDTH:  cfg_d.use_width  = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_limit <= STEP_LIMIT_RST;
      cfg_q.tolerance  <= TOLERANCE_RST;
      cfg_q.use_value  <= 1'b1;
      cfg_q.use_width  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ hdl/bisr_step.sv @@
`timescale 1ns / 1ps

module bisr_step import bisr_pkg::*; (
  input  item_t   item_i,
  input  state_t  state_i,
  input  cfg_t    cfg_i,
  output state_t  state_o,
  output result_t result_o
);

  logic               value_on;
  logic               width_on;
  logic               fv_ok;
  logic [VALUE_W-1:0] fv;
  logic [VALUE_W-1:0] lo_s;
  logic [VALUE_W-1:0] hi_s;
  logic [VALUE_W-1:0] lv_s;
  logic [STEP_W-1:0]  steps_s;
  logic [VALUE_W-1:0] adv_mid;
  logic [VALUE_W-1:0] span;
  logic               limit_hit;
  logic               narrow;

  // with both tests off, both apply
  assign value_on = cfg_i.use_value || !cfg_i.use_width;
  assign width_on = cfg_i.use_width || !cfg_i.use_value;
  assign fv       = item_i.func_value;
  assign fv_ok    = value_on && (mag(fv) <= {1'b0, cfg_i.tolerance});

  // bracket after the midpoint value has moved one side
  always_comb begin
    lo_s    = state_i.low_end;
    hi_s    = state_i.high_end;
    lv_s    = state_i.low_value;
    steps_s = state_i.steps_done;
    if (state_i.phase == PH_MID) begin
      steps_s = state_i.steps_done + STEP_W'(1);
      if (brackets(state_i.low_value, fv)) begin
        hi_s = state_i.last_mid;
      end else begin
        lo_s = state_i.last_mid;
        lv_s = fv;
      end
    end
  end

  // next midpoint and stop tests
  assign adv_mid   = midpoint(lo_s, hi_s);
  assign span      = hi_s - lo_s;
  assign limit_hit = steps_s >= cfg_i.step_limit;
  assign narrow    = width_on && (span <= {1'b0, cfg_i.tolerance});

  always_comb begin
    state_o         = state_i;
    result_o.status = ST_IGNORED;
    result_o.point  = '0;
    if (item_i.cmd == CMD_START) begin
      // order the endpoints
      if ($signed(item_i.end_a) <= $signed(item_i.end_b)) begin
        state_o.low_end  = item_i.end_a;
        state_o.high_end = item_i.end_b;
      end else begin
        state_o.low_end  = item_i.end_b;
        state_o.high_end = item_i.end_a;
      end
      state_o.low_value  = '0;
      state_o.last_mid   = '0;
      state_o.steps_done = '0;
      state_o.phase      = PH_LOW;
      result_o.status    = ST_EVAL;
      result_o.point     = state_o.low_end;
    end else begin
      case (state_i.phase)
        PH_LOW: begin
          state_o.low_value = fv;
          if (fv_ok) begin
            state_o.phase   = PH_IDLE;
            result_o.status = ST_FOUND;
            result_o.point  = state_i.low_end;
          end else begin
            state_o.phase   = PH_HIGH;
            result_o.status = ST_EVAL;
            result_o.point  = state_i.high_end;
          end
        end
        PH_HIGH, PH_MID: begin
          state_o.steps_done = steps_s;
          if (fv_ok) begin
            state_o.phase   = PH_IDLE;
            result_o.status = ST_FOUND;
            result_o.point  = (state_i.phase == PH_HIGH) ? state_i.high_end
                                                         : state_i.last_mid;
          end else if (state_i.phase == PH_HIGH &&
                       !brackets(state_i.low_value, fv)) begin
            // no sign change across the interval
            state_o.phase   = PH_IDLE;
            result_o.status = ST_NOCONV;
            result_o.point  = adv_mid;
          end else begin
            state_o.low_end   = lo_s;
            state_o.high_end  = hi_s;
            state_o.low_value = lv_s;
            if (limit_hit) begin
              state_o.phase   = PH_IDLE;
              result_o.status = ST_NOCONV;
              result_o.point  = state_i.last_mid;
            end else if (narrow) begin
              state_o.phase   = PH_IDLE;
              result_o.status = ST_FOUND;
              result_o.point  = adv_mid;
            end else begin
              state_o.last_mid = adv_mid;
              state_o.phase    = PH_MID;
              result_o.status  = ST_EVAL;
              result_o.point   = adv_mid;
            end
          end
        end
        default: begin
          result_o.status = ST_IGNORED;
          result_o.point  = '0;
        end
      endcase
    end
  end

endmodule

@@ hdl/bisection_root_sequencer_core.sv @@
`timescale 1ns / 1ps

// Bisection root search sequencer, Q16.16. A transaction with tuser 0 starts a
// search on the endpoints in tdata; each result asks the external evaluator
// for f at a point (status 0) or ends the search with the answer (status 1
// found, 2 not converged). Send the requested f back with tuser 1; a value
// sent while no search runs returns status 3. Exactly one result comes per
// input transaction. One transaction is taken every cycle while the result
// register is free or being emptied; a result passes through the input
// register and the result register around a combinational update of the
// search state. Write configuration only while no result is outstanding.
module bisection_root_sequencer_core import bisr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // end_a, end_b, func_value
  input  logic [0:0]       s_axis_tuser,  // cmd
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [VALUE_W-1:0] m_axis_tdata,  // point
  output logic [1:0]       m_axis_tuser,  // status
  // configuration writes
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_valid_q;
  state_t  state_q, state_d;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    advance;

  bisr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bisr_step u_step (
    .item_i   (in_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // item moves on when the result register is free or being emptied
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.cmd        <= s_axis_tuser[0];
      in_q.end_a      <= s_axis_tdata[VALUE_W-1:0];
      in_q.end_b      <= s_axis_tdata[2*VALUE_W-1:VALUE_W];
      in_q.func_value <= s_axis_tdata[3*VALUE_W-1:2*VALUE_W];
    end
  end

  // search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, default: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q.point;
  assign m_axis_tuser  = res_q.status;

endmodule

@@ hdl/bisr_chk.sv @@
`timescale 1ns / 1ps

module bisr_chk import bisr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [VALUE_W-1:0] m_axis_tdata,
  input logic [1:0]         m_axis_tuser
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an ignored item reports a zero point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_IGNORED) |-> m_axis_tdata == '0)
    else $error("ignored item with nonzero point");

  // input stalls only behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // a fresh result follows an earlier input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without matching input transaction");

endmodule

bind bisection_root_sequencer_core bisr_chk u_bisr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bisr_pkg::*;

  typedef logic [VALUE_W-1:0] val_t;

  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 125;
  localparam int unsigned MAX_EVALS      = 80;
  localparam longint      Q_MAX          = 64'sd2147483647;
  localparam longint      Q_MIN          = -64'sd2147483648;

  // dut ports
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;  // end_a, end_b, func_value
  logic [0:0]       s_axis_tuser  = '0;  // cmd
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [VALUE_W-1:0] m_axis_tdata;      // point
  logic [1:0]       m_axis_tuser;        // status
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_W-1:0] cfg_data_i    = '0;

  // predictor copy of the registers and the search state
  logic [STEP_W-1:0] cfg_steps = STEP_LIMIT_RST;
  logic [TOL_W-1:0]  cfg_tol   = TOLERANCE_RST;
  logic              cfg_vt    = 1'b1;
  logic              cfg_wt    = 1'b1;
  phase_e            search_phase = PH_IDLE;
  val_t              lo_end      = '0;
  val_t              hi_end      = '0;
  val_t              lo_val      = '0;
  val_t              mid_pt      = '0;
  logic [STEP_W-1:0] steps_taken = '0;

  result_t     pending_results[$];
  int unsigned err_count   = 0;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  bit          steady_flow = 1'b0;

  // function under search: saturated line through root_pt
  val_t        root_pt   = '0;
  int          slope_k   = 1;
  int unsigned shift_k   = 0;
  int unsigned noise_pct = 0;

  logic [1:0]   got_status;
  val_t         got_point;
  result_t      want;

  bisection_root_sequencer_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic result_t make_result(input status_e s, input val_t p);
    result_t r;
    r.status = s;
    r.point  = p;
    return r;
  endfunction

  // floor of the mean, one extra bit keeps the sum exact
  function automatic val_t half_sum(input val_t x, input val_t y);
    logic [VALUE_W:0] s;
    s = {x[VALUE_W-1], x} + {y[VALUE_W-1], y};
    return s[VALUE_W:1];
  endfunction

  // |v| <= tolerance, the most negative value has magnitude 2^31
  function automatic logic settles(input val_t v);
    logic [VALUE_W:0] m;
    m = v[VALUE_W-1] ? ({(VALUE_W+1){1'b0}} - {1'b1, v}) : {1'b0, v};
    return (cfg_vt || !cfg_wt) && (m <= {2'b00, cfg_tol});
  endfunction

  function automatic logic opposite(input val_t x, input val_t y);
    return (x[VALUE_W-1] && !y[VALUE_W-1] && y != '0) ||
           (y[VALUE_W-1] && !x[VALUE_W-1] && x != '0);
  endfunction

  // step limit, then width test, then the next midpoint request
  function automatic result_t next_probe();
    val_t m;
    val_t w;
    if (steps_taken >= cfg_steps) begin
      search_phase = PH_IDLE;
      return make_result(ST_NOCONV, mid_pt);
    end
    m = half_sum(lo_end, hi_end);
    w = hi_end - lo_end;
    if ((cfg_wt || !cfg_vt) && w <= {1'b0, cfg_tol}) begin
      search_phase = PH_IDLE;
      return make_result(ST_FOUND, m);
    end
    mid_pt       = m;
    search_phase = PH_MID;
    return make_result(ST_EVAL, m);
  endfunction

  function automatic result_t bisect_predict(input logic [0:0] cmd, input val_t a,
                                             input val_t b, input val_t fv);
    result_t r;
    if (cmd == CMD_START) begin
      if ($signed(a) <= $signed(b)) begin
        lo_end = a;
        hi_end = b;
      end else begin
        lo_end = b;
        hi_end = a;
      end
      lo_val       = '0;
      mid_pt       = '0;
      steps_taken  = '0;
      search_phase = PH_LOW;
      return make_result(ST_EVAL, lo_end);
    end
    case (search_phase)
      PH_LOW: begin
        lo_val = fv;
        if (settles(fv)) begin
          search_phase = PH_IDLE;
          r = make_result(ST_FOUND, lo_end);
        end else begin
          search_phase = PH_HIGH;
          r = make_result(ST_EVAL, hi_end);
        end
      end
      PH_HIGH: begin
        if (settles(fv)) begin
          search_phase = PH_IDLE;
          r = make_result(ST_FOUND, hi_end);
        end else if (!opposite(lo_val, fv)) begin
          search_phase = PH_IDLE;
          r = make_result(ST_NOCONV, half_sum(lo_end, hi_end));
        end else begin
          r = next_probe();
        end
      end
      PH_MID: begin
        steps_taken = steps_taken + 1'b1;
        if (settles(fv)) begin
          search_phase = PH_IDLE;
          r = make_result(ST_FOUND, mid_pt);
        end else begin
          // keep the half whose ends still differ in sign
          if (opposite(lo_val, fv)) begin
            hi_end = mid_pt;
          end else begin
            lo_end = mid_pt;
            lo_val = fv;
          end
          r = next_probe();
        end
      end
      default: r = make_result(ST_IGNORED, '0);
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input val_t got, input val_t exp_v);
    err_count++;
    $display("mismatch: %s got %h exp %h at %0t", what, got, exp_v, $realtime);
  endtask

  // sample at the edge, compare once the edge has settled
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_status = m_axis_tuser;
      got_point  = m_axis_tdata;
      #1;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", got_point, '0);
      end else begin
        want = pending_results.pop_front();
        if (got_status !== want.status) begin
          report_mismatch("status", val_t'(got_status), val_t'(want.status));
        end
        if (got_point !== want.point) begin
          report_mismatch("point", got_point, want.point);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- idling

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 99) < 25) begin
      stall_left    <= idle_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- drivers

  // one input transaction, prediction taken at the accepting edge
  task automatic send_item(input logic [0:0] cmd, input val_t a, input val_t b,
                           input val_t fv, output result_t res);
    int unsigned gap;
    gap = (!steady_flow && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {fv, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    res = bisect_predict(cmd, a, b, fv);
    pending_results.push_back(res);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_STEP_LIMIT: cfg_steps = data[STEP_W-1:0];
      REG_TOLERANCE:  cfg_tol   = data[TOL_W-1:0];
      REG_USE_VALUE:  cfg_vt    = data[0];
      REG_USE_WIDTH:  cfg_wt    = data[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // all four registers, unused upper bits random
  task automatic set_config(input logic [STEP_W-1:0] steps, input logic [TOL_W-1:0] tol,
                            input logic vt, input logic wt);
    write_reg(REG_STEP_LIMIT, {16'($urandom), steps});
    write_reg(REG_TOLERANCE, {1'($urandom), tol});
    write_reg(REG_USE_VALUE, {31'($urandom), vt});
    write_reg(REG_USE_WIDTH, {31'($urandom), wt});
  endtask

  // ---------------------------------------------------------------- evaluator

  function automatic val_t probe_value(input val_t x);
    longint d;
    if ($urandom_range(0, 99) < noise_pct) return $urandom;
    d = (longint'($signed(x)) - longint'($signed(root_pt))) * slope_k;
    d = d >>> shift_k;
    if (d > Q_MAX) return 32'h7FFF_FFFF;
    if (d < Q_MIN) return 32'h8000_0000;
    return val_t'(d);
  endfunction

  function automatic val_t pick_end();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return val_t'($urandom_range(0, 1 << 19)) - val_t'(1 << 18);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_steps();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return STEP_W'($urandom_range(1, 3));
      2: return STEP_W'($urandom_range(0, 40));
      3: return STEP_LIMIT_RST;
      default: return '1;
    endcase
  endfunction

  function automatic logic [TOL_W-1:0] pick_tol();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return TOL_W'($urandom_range(0, 15));
      3: return TOL_W'($urandom_range(0, 1 << 20));
      default: return TOL_W'($urandom);
    endcase
  endfunction

  // one search with random content, sometimes cut short or padded with noise
  task automatic run_search();
    val_t         a;
    val_t         b;
    longint       lo_s;
    longint       hi_s;
    longint       tmp;
    longint unsigned span;
    result_t      res;
    int unsigned  evals;
    steady_flow = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 9) == 0) begin
      send_item(1'($urandom), $urandom, $urandom, $urandom, res);
    end
    case ($urandom_range(0, 3))
      0: begin
        a = $urandom;
        b = $urandom;
      end
      1: begin
        a = $urandom;
        b = a + val_t'($urandom_range(0, 1 << $urandom_range(0, 20)));
      end
      2: begin
        a = pick_end();
        b = pick_end();
      end
      default: begin
        b = $urandom_range(1, 1 << 20);
        a = -b;
      end
    endcase
    // root mostly inside the interval
    lo_s = longint'($signed(a));
    hi_s = longint'($signed(b));
    if (lo_s > hi_s) begin
      tmp  = lo_s;
      lo_s = hi_s;
      hi_s = tmp;
    end
    span = longint'(hi_s - lo_s) + 1;
    if ($urandom_range(0, 4) != 0) root_pt = val_t'(lo_s + longint'({$urandom, $urandom} % span));
    else root_pt = $urandom;
    slope_k   = int'($urandom_range(0, 8)) - 4;
    shift_k   = $urandom_range(0, 16);
    noise_pct = ($urandom_range(0, 4) == 0) ? 20 : 0;

    send_item(CMD_START, a, b, $urandom, res);
    evals = 0;
    while (res.status == ST_EVAL && evals < MAX_EVALS && $urandom_range(0, 99) != 0) begin
      send_item(CMD_VALUE, $urandom, $urandom, probe_value(res.point), res);
      evals++;
    end
    if ($urandom_range(0, 7) == 0) begin
      send_item(CMD_VALUE, $urandom, $urandom, $urandom, res);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_ignored_value();
    result_t res;
    send_item(CMD_VALUE, '1, '0, 32'h8000_0000, res);
  endtask

  // swapped extreme endpoints, value hits at either end
  task automatic test_found_at_endpoints();
    result_t res;
    send_item(CMD_START, 32'h7FFF_FFFF, 32'h8000_0000, '0, res);
    send_item(CMD_VALUE, '0, '1, 32'h8000_0000, res);
    send_item(CMD_VALUE, '1, '0, val_t'(-7), res);
    send_item(CMD_START, val_t'(-65536), val_t'(65536), '1, res);
    send_item(CMD_VALUE, '0, '0, val_t'(7), res);
  endtask

  task automatic test_unbracketed();
    result_t res;
    send_item(CMD_START, '0, val_t'(65536), '0, res);
    send_item(CMD_VALUE, '0, '0, val_t'(32'h0001_0000), res);
    send_item(CMD_VALUE, '0, '0, val_t'(32'h0002_0000), res);
  endtask

  task automatic test_restart_mid_search();
    result_t res;
    send_item(CMD_START, val_t'(-100), val_t'(100), '0, res);
    send_item(CMD_VALUE, '0, '0, val_t'(-5000), res);
    send_item(CMD_START, val_t'(50), val_t'(-50), '0, res);
    send_item(CMD_VALUE, '0, '0, '0, res);
  endtask

  // limit zero gives point zero, limit two gives the last midpoint
  task automatic test_step_limit();
    result_t res;
    set_config('0, TOLERANCE_RST, 1'b1, 1'b1);
    send_item(CMD_START, val_t'(-65536), val_t'(65536), '0, res);
    send_item(CMD_VALUE, '0, '0, val_t'(-65536), res);
    send_item(CMD_VALUE, '0, '0, val_t'(65536), res);
    set_config(STEP_W'(2), TOLERANCE_RST, 1'b1, 1'b1);
    send_item(CMD_START, val_t'(1000), val_t'(-1000), '0, res);
    send_item(CMD_VALUE, '0, '0, val_t'(-1000), res);
    send_item(CMD_VALUE, '0, '0, val_t'(1000), res);
    send_item(CMD_VALUE, '0, '0, val_t'(30), res);
    send_item(CMD_VALUE, '0, '0, val_t'(-20), res);
  endtask

  // both tests off means both apply, then width test alone
  task automatic test_test_selection();
    result_t res;
    set_config(STEP_LIMIT_RST, '1, 1'b0, 1'b0);
    send_item(CMD_START, val_t'(-1), val_t'(1), '0, res);
    send_item(CMD_VALUE, '0, '0, val_t'(5), res);
    set_config(STEP_LIMIT_RST, TOLERANCE_RST, 1'b0, 1'b1);
    send_item(CMD_START, 32'h8000_0000, 32'h7FFF_FFFF, '0, res);
    send_item(CMD_VALUE, '0, '0, '0, res);
    send_item(CMD_VALUE, '0, '0, '0, res);
  endtask

  task automatic test_random_searches();
    int unsigned stop_at;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config('1, '0, 1'b1, 1'b1);
        1: set_config('0, '1, 1'b1, 1'b0);
        2: set_config(STEP_LIMIT_RST, TOLERANCE_RST, 1'b1, 1'b1);
        default: set_config(pick_steps(), pick_tol(), 1'($urandom), 1'($urandom));
      endcase
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) run_search();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ignored_value();
    test_found_at_endpoints();
    test_unbracketed();
    test_restart_mid_search();
    test_step_limit();
    test_test_selection();
    test_random_searches();
    wait_drained();
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/bisr_pkg.sv
hdl/bisr_cfg.sv
hdl/bisr_step.sv
hdl/bisection_root_sequencer_core.sv
hdl/bisr_chk.sv
tb/testbench.sv
